// ===== rtl/sase_pkg.sv =====
// shared types and constants for the small arm subset executor
// no dependencies; imported by every module of the block and by the item and config interfaces
`default_nettype none

package sase_pkg;

    localparam int STACK_BYTES = 8192;
    localparam int REG_COUNT   = 32;
    localparam int REG_AW      = $clog2(REG_COUNT);
    localparam int STACK_ROWS  = STACK_BYTES / 4;
    localparam int SLOT_W      = $clog2(STACK_BYTES);
    localparam int ROW_AW      = SLOT_W - 2;
    localparam int CFG_IDX_W   = 4;

    localparam logic [30:0] RESET_STACK_TOP = 31'h7fff_fffc;
    localparam logic [30:0] RESET_CODE_BASE = 31'h0000_4000;
    localparam logic [REG_AW-1:0] SP_REG    = REG_AW'(28);
    localparam logic [REG_AW-1:0] LINK_REG  = REG_AW'(30);
    localparam logic [REG_AW-1:0] ZERO_REG  = REG_AW'(0);
    localparam logic [31:0] PC_STEP         = 32'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_STACK_TOP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_MOV   = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MUL   = 4'd4,
        OP_CMP   = 4'd5,
        OP_B     = 4'd6,
        OP_BL    = 4'd7,
        OP_BGE   = 4'd8,
        OP_LDR   = 4'd9,
        OP_STR   = 4'd10,
        OP_PRINT = 4'd11,
        OP_EXIT  = 4'd12
    } op_t;

    typedef struct packed {
        logic [3:0]        operation;
        logic [REG_AW-1:0] dest_reg;
        logic              dest_is_pc;
        logic [REG_AW-1:0] src_a_reg;
        logic              src_a_is_imm;
        logic [31:0]       imm_a;
        logic [REG_AW-1:0] src_b_reg;
        logic              src_b_is_imm;
        logic [31:0]       imm_b;
        logic [31:0]       branch_target;
    } item_t;

    typedef struct packed {
        logic [31:0]       next_pc;
        logic              flag_n;
        logic              flag_z;
        logic              rf_we;
        logic [REG_AW-1:0] rf_addr;
        logic [31:0]       rf_data;
        logic              is_load;
        logic              is_store;
        logic [31:0]       mem_addr;
        logic [31:0]       store_data;
        logic              print_valid;
        logic [31:0]       print_value;
        logic              halted;
    } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/sase_item_if.sv =====
// instruction item channel: valid/ready handshake plus decoded fields
// depends on sase_pkg
`default_nettype none

interface sase_item_if;
    import sase_pkg::*;

    logic              valid;
    logic              ready;
    logic [3:0]        operation;
    logic [REG_AW-1:0] dest_reg;
    logic              dest_is_pc;
    logic [REG_AW-1:0] src_a_reg;
    logic              src_a_is_imm;
    logic signed [31:0] imm_a;
    logic [REG_AW-1:0] src_b_reg;
    logic              src_b_is_imm;
    logic signed [31:0] imm_b;
    logic [31:0]       branch_target;

    modport source (
        output valid, operation, dest_reg, dest_is_pc, src_a_reg, src_a_is_imm,
               imm_a, src_b_reg, src_b_is_imm, imm_b, branch_target,
        input  ready
    );
    modport sink (
        input  valid, operation, dest_reg, dest_is_pc, src_a_reg, src_a_is_imm,
               imm_a, src_b_reg, src_b_is_imm, imm_b, branch_target,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sase_result_if.sv =====
// result channel: valid/ready handshake plus pc, flags and print/exit status
// no dependencies
`default_nettype none

interface sase_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        next_pc;
    logic               flag_negative;
    logic               flag_zero;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               halted;

    modport source (
        output valid, next_pc, flag_negative, flag_zero, print_valid, print_value,
               halted,
        input  ready
    );
    modport sink (
        input  valid, next_pc, flag_negative, flag_zero, print_valid, print_value,
               halted,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sase_cfg_if.sv =====
// configuration write channel: register index and 31-bit write data
// depends on sase_pkg
`default_nettype none

interface sase_cfg_if;
    import sase_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [30:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sase_regbank.sv =====
// one copy of the 32-entry register file: one write port, two registered reads
// per-entry valid bits give the reset contents; depends on sase_pkg
`default_nettype none

module sase_regbank (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       ren,
    input  logic                       we,
    input  logic [sase_pkg::REG_AW-1:0] waddr,
    input  logic [31:0]                wdata,
    input  logic [sase_pkg::REG_AW-1:0] raddr0,
    input  logic [sase_pkg::REG_AW-1:0] raddr1,
    output logic [31:0]                rdata0,
    output logic [31:0]                rdata1
);
    import sase_pkg::*;

    logic [31:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [31:0]          q0_reg;
    logic [31:0]          q1_reg;
    logic                 v0_reg;
    logic                 v1_reg;
    logic                 sp0_reg;
    logic                 sp1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            q0_reg  <= mem[raddr0];
            q1_reg  <= mem[raddr1];
            sp0_reg <= (raddr0 == SP_REG);
            sp1_reg <= (raddr1 == SP_REG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (ren)
            begin
                v0_reg <= vld_reg[raddr0];
                v1_reg <= vld_reg[raddr1];
            end
        end
    end

    // never-written entries read as zero, the stack pointer as its reset value
    assign rdata0 = v0_reg ? q0_reg : (sp0_reg ? {1'b0, RESET_STACK_TOP} : 32'd0);
    assign rdata1 = v1_reg ? q1_reg : (sp1_reg ? {1'b0, RESET_STACK_TOP} : 32'd0);

endmodule

`default_nettype wire

// ===== rtl/sase_stack.sv =====
// byte stack store as four byte lanes, one word access per cycle, plus its
// clearing pass after reset; depends on sase_pkg
`default_nettype none

module sase_stack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        access_en,
    input  logic        is_store,
    input  logic [31:0] addr,
    input  logic [31:0] wdata,
    input  logic [30:0] stack_top,
    output logic [31:0] load_word,
    output logic        busy
);
    import sase_pkg::*;

    logic [31:0]             byte_addr [4];
    logic [32:0]             diff      [4];
    logic [3:0]              byte_ok;
    logic [SLOT_W-1:0]       slot      [4];
    logic [1:0]              lane_k    [4];
    logic [ROW_AW-1:0]       bank_row  [4];
    logic [7:0]              bank_wdata[4];
    logic [3:0]              bank_we;
    logic [1:0]              rd_lane   [4];
    logic [7:0]              mem [4][STACK_ROWS];
    logic [7:0]              q_reg [4];
    logic [3:0]              ok_reg;
    logic [1:0]              lane_reg;
    logic                    clr_busy_reg;
    logic [ROW_AW-1:0]       clr_row_reg;

    // byte k of the word lives at slot stack_top - (addr + k)
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            byte_addr[k] = addr + 32'(k);
            diff[k]      = {2'b00, stack_top} - {1'b0, byte_addr[k]};
            byte_ok[k]   = !diff[k][32] && (diff[k][31:0] < 32'(STACK_BYTES));
            slot[k]      = diff[k][SLOT_W-1:0];
        end
        // slots are consecutive, so each lane takes exactly one byte
        for (int j = 0; j < 4; j++)
        begin
            lane_k[j]     = slot[0][1:0] - 2'(j);
            bank_row[j]   = slot[lane_k[j]][SLOT_W-1:2];
            bank_wdata[j] = wdata[8*lane_k[j] +: 8];
            bank_we[j]    = access_en && is_store && byte_ok[lane_k[j]];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (clr_busy_reg)
            begin
                mem[j][clr_row_reg] <= 8'h00;
            end
            else if (bank_we[j])
            begin
                mem[j][bank_row[j]] <= bank_wdata[j];
            end
            if (access_en)
            begin
                q_reg[j] <= mem[j][bank_row[j]];
            end
        end
        if (access_en)
        begin
            ok_reg   <= byte_ok;
            lane_reg <= slot[0][1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_row_reg == ROW_AW'(STACK_ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    // bytes outside the store read as zero
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rd_lane[k]          = lane_reg - 2'(k);
            load_word[8*k +: 8] = ok_reg[k] ? q_reg[rd_lane[k]] : 8'h00;
        end
    end

    assign busy = clr_busy_reg;

endmodule

`default_nettype wire

// ===== rtl/sase_alu.sv =====
// execute logic: operand select, arithmetic, compare, branch resolution,
// register write and stack address; depends on sase_pkg
`default_nettype none

module sase_alu (
    input  sase_pkg::item_t    item,
    input  logic [31:0]        ra_val,
    input  logic [31:0]        rb_val,
    input  logic [31:0]        rd_val,
    input  logic [31:0]        pv_val,
    input  logic [31:0]        pc,
    input  logic               flag_n,
    input  logic               flag_z,
    output sase_pkg::alu_res_t res
);
    import sase_pkg::*;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] seq;
    logic [31:0] diff;
    logic [31:0] prod;

    always_comb
    begin
        a    = item.src_a_is_imm ? item.imm_a : ra_val;
        b    = item.src_b_is_imm ? item.imm_b : rb_val;
        seq  = pc + PC_STEP;
        diff = a - b;
        prod = a * b;

        res             = '0;
        res.next_pc     = seq;
        res.flag_n      = flag_n;
        res.flag_z      = flag_z;
        res.rf_addr     = item.dest_reg;
        res.mem_addr    = ra_val + b;
        res.store_data  = rd_val;

        case (op_t'(item.operation))
            OP_MOV:
            begin
                if (item.dest_is_pc)
                begin
                    res.next_pc = a;
                end
                else
                begin
                    res.rf_we   = 1'b1;
                    res.rf_data = a;
                end
            end
            OP_ADD:
            begin
                res.rf_we   = 1'b1;
                res.rf_data = a + b;
            end
            OP_SUB:
            begin
                res.rf_we   = 1'b1;
                res.rf_data = diff;
            end
            OP_MUL:
            begin
                res.rf_we   = 1'b1;
                res.rf_data = prod;
            end
            OP_CMP:
            begin
                res.flag_z = (diff == 32'd0);
                res.flag_n = diff[31];
            end
            OP_B:
            begin
                res.next_pc = item.branch_target;
            end
            OP_BL:
            begin
                res.rf_we   = 1'b1;
                res.rf_addr = LINK_REG;
                res.rf_data = seq;
                res.next_pc = item.branch_target;
            end
            OP_BGE:
            begin
                if (flag_z || !flag_n)
                begin
                    res.next_pc = item.branch_target;
                end
            end
            OP_LDR:
            begin
                res.rf_we   = 1'b1;
                res.is_load = 1'b1;
            end
            OP_STR:
            begin
                res.is_store = 1'b1;
            end
            OP_PRINT:
            begin
                res.print_valid = 1'b1;
                res.print_value = pv_val;
            end
            OP_EXIT:
            begin
                res.halted  = 1'b1;
                res.next_pc = pc;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/small_arm_subset_executor.sv =====
// top level of the small arm subset executor: operand read stage, execute,
// result register and register writeback; depends on sase_pkg, the three
// channel interfaces, sase_regbank, sase_stack and sase_alu
//
// One decoded instruction is taken per clock while the result channel does not
// stall, and its result beat is registered after the operand read registers.
// The operand read registers and the single execute pass set this rate. After
// reset the stack store runs a clearing pass over its STACK_BYTES/4 rows (2048
// at 8192 bytes) during which no instruction is taken; configuration writes are
// taken at any time and must come while the block is idle. A print that directly
// follows an instruction writing register 0 is held until that instruction has
// executed, since register 0 selects the printed register. Loads write their
// register from the writeback stage; later instructions see the value through forwarding.
`default_nettype none

module small_arm_subset_executor (
    input  logic          clk,
    input  logic          rst_n,
    sase_item_if.sink     item,
    sase_result_if.source result,
    sase_cfg_if.sink      cfg
);
    import sase_pkg::*;

    // read stage
    logic              r_valid_reg;
    item_t             item_reg;
    logic [REG_AW-1:0] pidx_reg;
    logic [REG_AW-1:0] pidx_next;
    logic [REG_AW-1:0] r0_lo_reg;
    logic [3:0]        pat_vld_reg;
    logic [31:0]       pat_data_reg [4];
    logic [REG_AW-1:0] opnd_addr [4];
    logic [REG_AW-1:0] new_addr  [4];
    logic [31:0]       bank_q    [4];
    logic [31:0]       opnd_val  [4];
    item_t             item_in;

    // architectural state held in flops
    logic [31:0]       pc_reg;
    logic              n_reg;
    logic              z_reg;
    logic [30:0]       stack_top_reg;

    // writeback stage
    logic              w_we_reg;
    logic [REG_AW-1:0] w_addr_reg;
    logic [31:0]       w_data_reg;
    logic              w_load_reg;

    // result register
    logic              out_valid_reg;
    logic [31:0]       out_pc_reg;
    logic              out_n_reg;
    logic              out_z_reg;
    logic              out_pv_reg;
    logic [31:0]       out_pval_reg;
    logic              out_halt_reg;

    alu_res_t          alu;
    logic              accept;
    logic              x_adv;
    logic              print_hazard;
    logic              stk_busy;
    logic [31:0]       load_word;
    logic              cfg_acc;
    logic              cfg_sp;
    logic              cfg_pc;
    logic              wr_en;
    logic [REG_AW-1:0] wr_addr;
    logic [31:0]       wr_data;

    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cfg_sp    = cfg_acc && (cfg.index == CFG_STACK_TOP);
    assign cfg_pc    = cfg_acc && (cfg.index == CFG_CODE_BASE);

    // single register write port shared by writeback and stack pointer config
    assign wr_en   = w_we_reg || cfg_sp;
    assign wr_addr = cfg_sp ? SP_REG : w_addr_reg;
    assign wr_data = cfg_sp ? {1'b0, cfg.data} : (w_load_reg ? load_word : w_data_reg);

    assign x_adv        = r_valid_reg && (!out_valid_reg || result.ready);
    assign print_hazard = r_valid_reg && alu.rf_we && (alu.rf_addr == ZERO_REG)
                          && (item.operation == 4'(OP_PRINT));
    assign item.ready   = !stk_busy && (!r_valid_reg || x_adv) && !print_hazard;
    assign accept       = item.valid && item.ready;

    always_comb
    begin
        item_in.operation     = item.operation;
        item_in.dest_reg      = item.dest_reg;
        item_in.dest_is_pc    = item.dest_is_pc;
        item_in.src_a_reg     = item.src_a_reg;
        item_in.src_a_is_imm  = item.src_a_is_imm;
        item_in.imm_a         = item.imm_a;
        item_in.src_b_reg     = item.src_b_reg;
        item_in.src_b_is_imm  = item.src_b_is_imm;
        item_in.imm_b         = item.imm_b;
        item_in.branch_target = item.branch_target;
    end

    // register 0 as it stands after this edge picks the printed register
    assign pidx_next = (wr_en && wr_addr == ZERO_REG) ? wr_data[REG_AW-1:0] : r0_lo_reg;

    always_comb
    begin
        new_addr[0]  = item.src_a_reg;
        new_addr[1]  = item.src_b_reg;
        new_addr[2]  = item.dest_reg;
        new_addr[3]  = pidx_next;
        opnd_addr[0] = item_reg.src_a_reg;
        opnd_addr[1] = item_reg.src_b_reg;
        opnd_addr[2] = item_reg.dest_reg;
        opnd_addr[3] = pidx_reg;
    end

    sase_regbank u_bank_ab (
        .clk    (clk),
        .rst_n  (rst_n),
        .ren    (accept),
        .we     (wr_en),
        .waddr  (wr_addr),
        .wdata  (wr_data),
        .raddr0 (item.src_a_reg),
        .raddr1 (item.src_b_reg),
        .rdata0 (bank_q[0]),
        .rdata1 (bank_q[1])
    );

    sase_regbank u_bank_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ren    (accept),
        .we     (wr_en),
        .waddr  (wr_addr),
        .wdata  (wr_data),
        .raddr0 (item.dest_reg),
        .raddr1 (pidx_next),
        .rdata0 (bank_q[2]),
        .rdata1 (bank_q[3])
    );

    // pending write first, then writes seen since the read, then the read data
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (wr_en && wr_addr == opnd_addr[i])
            begin
                opnd_val[i] = wr_data;
            end
            else if (pat_vld_reg[i])
            begin
                opnd_val[i] = pat_data_reg[i];
            end
            else
            begin
                opnd_val[i] = bank_q[i];
            end
        end
    end

    sase_alu u_alu (
        .item   (item_reg),
        .ra_val (opnd_val[0]),
        .rb_val (opnd_val[1]),
        .rd_val (opnd_val[2]),
        .pv_val (opnd_val[3]),
        .pc     (pc_reg),
        .flag_n (n_reg),
        .flag_z (z_reg),
        .res    (alu)
    );

    sase_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .access_en (x_adv && (alu.is_load || alu.is_store)),
        .is_store  (alu.is_store),
        .addr      (alu.mem_addr),
        .wdata     (alu.store_data),
        .stack_top (stack_top_reg),
        .load_word (load_word),
        .busy      (stk_busy)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            pat_vld_reg   <= '0;
            r0_lo_reg     <= '0;
            pc_reg        <= {1'b0, RESET_CODE_BASE};
            n_reg         <= 1'b0;
            z_reg         <= 1'b0;
            stack_top_reg <= RESET_STACK_TOP;
            w_we_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (x_adv)
            begin
                r_valid_reg <= 1'b0;
            end

            for (int i = 0; i < 4; i++)
            begin
                if (accept)
                begin
                    pat_vld_reg[i] <= wr_en && (wr_addr == new_addr[i]);
                end
                else if (wr_en && wr_addr == opnd_addr[i])
                begin
                    pat_vld_reg[i] <= 1'b1;
                end
            end

            if (wr_en && wr_addr == ZERO_REG)
            begin
                r0_lo_reg <= wr_data[REG_AW-1:0];
            end

            if (cfg_sp)
            begin
                stack_top_reg <= cfg.data;
            end

            if (cfg_pc)
            begin
                pc_reg <= {1'b0, cfg.data};
            end
            else if (x_adv)
            begin
                pc_reg <= alu.next_pc;
            end

            if (x_adv)
            begin
                n_reg <= alu.flag_n;
                z_reg <= alu.flag_z;
            end

            w_we_reg <= x_adv && alu.rf_we;

            if (x_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
            pidx_reg <= pidx_next;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (accept || (wr_en && wr_addr == opnd_addr[i]))
            begin
                pat_data_reg[i] <= wr_data;
            end
        end
        if (x_adv)
        begin
            w_addr_reg   <= alu.rf_addr;
            w_data_reg   <= alu.rf_data;
            w_load_reg   <= alu.is_load;
            out_pc_reg   <= alu.next_pc;
            out_n_reg    <= alu.flag_n;
            out_z_reg    <= alu.flag_z;
            out_pv_reg   <= alu.print_valid;
            out_pval_reg <= alu.print_value;
            out_halt_reg <= alu.halted;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.next_pc       = out_pc_reg;
    assign result.flag_negative = out_n_reg;
    assign result.flag_zero     = out_z_reg;
    assign result.print_valid   = out_pv_reg;
    assign result.print_value   = out_pval_reg;
    assign result.halted        = out_halt_reg;

endmodule

`default_nettype wire

// ===== bench/sase_outcome_checker.sv =====
`timescale 1ns / 100ps
// result checker for the small arm subset executor: keeps its own copy of the
// registers, pc, flags and stack bytes, predicts every result beat and compares
// depends on sase_pkg and the item, result and config channel interfaces

module sase_outcome_checker (
    input  logic   clk,
    input  logic   rst_n,
    sase_item_if   item,
    sase_result_if result,
    sase_cfg_if    cfg,
    output int     mismatches,
    output int     outstanding
);
    import sase_pkg::*;

    typedef struct {
        logic [31:0] next_pc;
        logic        flag_n;
        logic        flag_z;
        logic        print_valid;
        logic [31:0] print_value;
        logic        halted;
    } outcome_t;

    logic [31:0] gpr [REG_COUNT];
    logic [31:0] pc;
    logic        neg_flag;
    logic        zero_flag;
    logic [31:0] stack_top;
    logic [7:0]  stack_mem [STACK_BYTES];
    outcome_t    expected_outcomes [$];
    int          fail_total = 0;
    int          queued = 0;

    assign mismatches  = fail_total;
    assign outstanding = queued;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_total++;
        $display("%0t result beat: %s got %h, predicted %h", $time, field, got, want);
    endtask

    // byte store index for an address, or nothing when outside the stack
    function automatic bit stack_slot(input logic [31:0] addr, output int slot);
        logic [31:0] depth;
        slot = 0;
        if (addr > stack_top)
            return 1'b0;
        depth = stack_top - addr;
        if (depth >= STACK_BYTES)
            return 1'b0;
        slot = int'(depth);
        return 1'b1;
    endfunction

    function automatic logic [31:0] fetch_word(input logic [31:0] addr);
        logic [31:0] word;
        int          slot;
        word = '0;
        for (int k = 0; k < 4; k++)
            if (stack_slot(addr + 32'(k), slot))
                word[8*k +: 8] = stack_mem[slot];
        return word;
    endfunction

    function automatic void put_word(input logic [31:0] addr, input logic [31:0] word);
        int slot;
        for (int k = 0; k < 4; k++)
            if (stack_slot(addr + 32'(k), slot))
                stack_mem[slot] = word[8*k +: 8];
    endfunction

    function automatic outcome_t run_instruction(input item_t ins);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] seq;
        logic [31:0] nxt;
        logic [31:0] diff;
        outcome_t    o;
        a = ins.src_a_is_imm ? ins.imm_a : gpr[ins.src_a_reg];
        b = ins.src_b_is_imm ? ins.imm_b : gpr[ins.src_b_reg];
        seq = pc + PC_STEP;
        nxt = seq;
        o.print_valid = 1'b0;
        o.print_value = '0;
        o.halted = 1'b0;
        case (ins.operation)
            OP_MOV:
                if (ins.dest_is_pc)
                    nxt = a;
                else
                    gpr[ins.dest_reg] = a;
            OP_ADD: gpr[ins.dest_reg] = a + b;
            OP_SUB: gpr[ins.dest_reg] = a - b;
            OP_MUL: gpr[ins.dest_reg] = a * b;
            OP_CMP:
            begin
                diff = a - b;
                zero_flag = (diff == '0);
                neg_flag = diff[31];
            end
            OP_B: nxt = ins.branch_target;
            OP_BL:
            begin
                gpr[LINK_REG] = seq;
                nxt = ins.branch_target;
            end
            OP_BGE:
                if (zero_flag || !neg_flag)
                    nxt = ins.branch_target;
            // base is always a register, the a-immediate flag plays no part
            OP_LDR: gpr[ins.dest_reg] = fetch_word(gpr[ins.src_a_reg] + b);
            OP_STR: put_word(gpr[ins.src_a_reg] + b, gpr[ins.dest_reg]);
            OP_PRINT:
            begin
                o.print_valid = 1'b1;
                o.print_value = gpr[gpr[ZERO_REG][REG_AW-1:0]];
            end
            OP_EXIT:
            begin
                o.halted = 1'b1;
                nxt = pc;
            end
            default: ;
        endcase
        pc = nxt;
        o.next_pc = pc;
        o.flag_n = neg_flag;
        o.flag_z = zero_flag;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        item_t    ins;
        if (!rst_n)
        begin
            foreach (gpr[i])
                gpr[i] = '0;
            foreach (stack_mem[i])
                stack_mem[i] = '0;
            stack_top = {1'b0, RESET_STACK_TOP};
            gpr[SP_REG] = stack_top;
            pc = {1'b0, RESET_CODE_BASE};
            neg_flag = 1'b0;
            zero_flag = 1'b0;
            expected_outcomes.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_outcomes.size() == 0)
                    report_mismatch("unexpected beat, next_pc", result.next_pc, '0);
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (result.next_pc !== want.next_pc)
                        report_mismatch("next_pc", result.next_pc, want.next_pc);
                    if (result.flag_negative !== want.flag_n)
                        report_mismatch("flag_negative", 32'(result.flag_negative),
                                        32'(want.flag_n));
                    if (result.flag_zero !== want.flag_z)
                        report_mismatch("flag_zero", 32'(result.flag_zero),
                                        32'(want.flag_z));
                    if (result.print_valid !== want.print_valid)
                        report_mismatch("print_valid", 32'(result.print_valid),
                                        32'(want.print_valid));
                    if (result.print_value !== want.print_value)
                        report_mismatch("print_value", result.print_value,
                                        want.print_value);
                    if (result.halted !== want.halted)
                        report_mismatch("halted", 32'(result.halted), 32'(want.halted));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                // both writes also load the architectural copy they seed
                if (cfg.index == CFG_STACK_TOP)
                begin
                    stack_top = {1'b0, cfg.data};
                    gpr[SP_REG] = stack_top;
                end
                else if (cfg.index == CFG_CODE_BASE)
                    pc = {1'b0, cfg.data};
            end
            if (item.valid && item.ready)
            begin
                ins.operation     = item.operation;
                ins.dest_reg      = item.dest_reg;
                ins.dest_is_pc    = item.dest_is_pc;
                ins.src_a_reg     = item.src_a_reg;
                ins.src_a_is_imm  = item.src_a_is_imm;
                ins.imm_a         = item.imm_a;
                ins.src_b_reg     = item.src_b_reg;
                ins.src_b_is_imm  = item.src_b_is_imm;
                ins.imm_b         = item.imm_b;
                ins.branch_target = item.branch_target;
                expected_outcomes.push_back(run_instruction(ins));
            end
        end
        queued = expected_outcomes.size();
    end

endmodule

// ===== bench/small_arm_subset_executor_tb.sv =====
`timescale 1ns / 100ps
// top of the executor bench: clock, reset, instruction and config stimulus,
// result back-pressure and the verdict; depends on sase_pkg, the channel
// interfaces, small_arm_subset_executor and sase_outcome_checker

module small_arm_subset_executor_tb;
    import sase_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int MAX_GAP          = 12;
    localparam int MODE_RUN         = 40;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = CFG_IDX_W'(15);
    localparam logic [3:0]           OP_LAST_CODE = 4'd15;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   cycles = 0;
    int   sent_count = 0;
    bit   src_calm;
    bit   sink_calm;

    sase_item_if   item_ch ();
    sase_result_if result_ch ();
    sase_cfg_if    cfg_ch ();

    small_arm_subset_executor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    sase_outcome_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL small_arm_subset_executor");
            $finish;
        end
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic item_t alu(input op_t op, input logic [REG_AW-1:0] rd,
                                  input bit a_imm, input logic [REG_AW-1:0] ra,
                                  input logic [31:0] ia, input bit b_imm,
                                  input logic [REG_AW-1:0] rb, input logic [31:0] ib);
        item_t ins;
        ins = '0;
        ins.operation    = op;
        ins.dest_reg     = rd;
        ins.src_a_is_imm = a_imm;
        ins.src_a_reg    = ra;
        ins.imm_a        = ia;
        ins.src_b_is_imm = b_imm;
        ins.src_b_reg    = rb;
        ins.imm_b        = ib;
        return ins;
    endfunction

    function automatic item_t mem(input op_t op, input logic [REG_AW-1:0] rd,
                                  input logic [REG_AW-1:0] base, input bit b_imm,
                                  input logic [REG_AW-1:0] rb, input logic [31:0] ib);
        return alu(op, rd, 1'b0, base, '0, b_imm, rb, ib);
    endfunction

    function automatic item_t jump(input op_t op, input logic [31:0] target);
        item_t ins;
        ins = '0;
        ins.operation     = op;
        ins.branch_target = target;
        return ins;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'($urandom_range(0, 2 * STACK_BYTES)) - 32'(STACK_BYTES);
            default: return $urandom();
        endcase
    endfunction

    // keep the stack pointer mostly intact so loads and stores stay in the store
    function automatic logic [REG_AW-1:0] pick_dest();
        int r;
        if ($urandom_range(0, 39) == 0)
            return SP_REG;
        r = $urandom_range(0, REG_COUNT - 2);
        if (r >= SP_REG)
            r++;
        return REG_AW'(r);
    endfunction

    function automatic item_t random_instr();
        item_t ins;
        int    pick;
        ins = $bits(item_t)'({$urandom(), $urandom(), $urandom(), $urandom()});
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            ins.operation  = 4'($urandom_range(OP_MOV, OP_CMP));
            ins.dest_reg   = pick_dest();
            ins.dest_is_pc = ($urandom_range(0, 9) == 0);
            ins.imm_a      = pick_value();
            ins.imm_b      = pick_value();
        end
        else if (pick < 52)
            ins.operation = 4'($urandom_range(OP_B, OP_BGE));
        else if (pick < 84)
        begin
            ins.operation = ($urandom_range(0, 1) != 0) ? OP_LDR : OP_STR;
            if (ins.operation == OP_LDR)
                ins.dest_reg = pick_dest();
            if ($urandom_range(0, 4) != 0)
                ins.src_a_reg = SP_REG;
            ins.src_b_is_imm = ($urandom_range(0, 3) != 0);
            ins.imm_b = 32'd4 - 32'($urandom_range(0, STACK_BYTES + 8));
        end
        else if (pick < 92)
            ins.operation = OP_PRINT;
        else if (pick < 95)
            ins.operation = OP_EXIT;
        else if (pick < 97)
            ins.operation = OP_NONE;
        else
            ins.operation = 4'($urandom_range(OP_EXIT + 1, OP_LAST_CODE));
        return ins;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_instr(input item_t ins);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.operation     <= ins.operation;
        item_ch.dest_reg      <= ins.dest_reg;
        item_ch.dest_is_pc    <= ins.dest_is_pc;
        item_ch.src_a_reg     <= ins.src_a_reg;
        item_ch.src_a_is_imm  <= ins.src_a_is_imm;
        item_ch.imm_a         <= ins.imm_a;
        item_ch.src_b_reg     <= ins.src_b_reg;
        item_ch.src_b_is_imm  <= ins.src_b_is_imm;
        item_ch.imm_b         <= ins.imm_b;
        item_ch.branch_target <= ins.branch_target;
        item_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
        if (sent_count % MODE_RUN == 0)
            src_calm = ($urandom_range(0, 3) == 0);
    endtask

    // valid is left high so back-to-back writes need no extra edge
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_directed();
        item_t ins;
        send_instr(alu(OP_MOV, 1, 1'b1, 0, 32'h7fff_ffff, 1'b1, 0, '0));
        send_instr(alu(OP_MOV, 2, 1'b1, 0, 32'h8000_0000, 1'b1, 0, '0));
        send_instr(alu(OP_ADD, 3, 1'b0, 1, '0, 1'b1, 0, 32'd1));
        send_instr(alu(OP_SUB, 4, 1'b0, 2, '0, 1'b1, 0, 32'd1));
        send_instr(alu(OP_MUL, 5, 1'b0, 1, '0, 1'b0, 1, '0));
        // equal compare sets Z, then bge taken on Z
        send_instr(alu(OP_CMP, 0, 1'b0, 1, '0, 1'b0, 1, '0));
        send_instr(jump(OP_BGE, 32'h0000_2000));
        // 0 - 1 sets N with Z clear, bge falls through
        send_instr(alu(OP_CMP, 0, 1'b1, 0, '0, 1'b1, 0, 32'd1));
        send_instr(jump(OP_BGE, 32'h0000_5000));
        send_instr(alu(OP_CMP, 0, 1'b0, 2, '0, 1'b0, 1, '0));
        send_instr(jump(OP_BGE, 32'h0000_3000));
        // link value wraps past the top of the address space
        send_instr(jump(OP_B, 32'hffff_fffc));
        send_instr(jump(OP_BL, 32'h0000_1234));
        // word at the stack top: only its low byte is inside the store
        send_instr(mem(OP_STR, 1, SP_REG, 1'b1, 0, '0));
        send_instr(mem(OP_STR, 2, SP_REG, 1'b1, 0, -32'sd4));
        send_instr(mem(OP_LDR, 7, SP_REG, 1'b1, 0, '0));
        ins = mem(OP_LDR, 8, SP_REG, 1'b1, 0, -32'sd4);
        ins.src_a_is_imm = 1'b1;
        ins.imm_a = '1;
        send_instr(ins);
        // straddles the bottom of the store
        send_instr(mem(OP_STR, 1, SP_REG, 1'b1, 0, -32'(STACK_BYTES + 2)));
        send_instr(mem(OP_LDR, 9, SP_REG, 1'b1, 0, -32'(STACK_BYTES + 2)));
        send_instr(alu(OP_MOV, 10, 1'b1, 0, -32'sd4, 1'b1, 0, '0));
        send_instr(mem(OP_LDR, 11, SP_REG, 1'b0, 10, '0));
        send_instr(alu(OP_MOV, ZERO_REG, 1'b1, 0, 32'd11, 1'b1, 0, '0));
        send_instr(alu(OP_PRINT, 0, 1'b0, 0, '0, 1'b0, 0, '0));
        ins = alu(OP_MOV, 0, 1'b1, 0, 32'h0000_1000, 1'b1, 0, '0);
        ins.dest_is_pc = 1'b1;
        send_instr(ins);
        send_instr(alu(OP_EXIT, 0, 1'b0, 0, '0, 1'b0, 0, '0));
        ins = alu(OP_NONE, 0, 1'b0, 0, '0, 1'b0, 0, '0);
        ins.operation = OP_LAST_CODE;
        send_instr(ins);
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        int taken;
        result_ch.ready = 1'b0;
        sink_calm = 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_gap(sink_calm);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            @(negedge clk);
            taken++;
            if (taken % MODE_RUN == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        src_calm = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.operation     = '0;
        item_ch.dest_reg      = '0;
        item_ch.dest_is_pc    = 1'b0;
        item_ch.src_a_reg     = '0;
        item_ch.src_a_is_imm  = 1'b0;
        item_ch.imm_a         = '0;
        item_ch.src_b_reg     = '0;
        item_ch.src_b_is_imm  = 1'b0;
        item_ch.imm_b         = '0;
        item_ch.branch_target = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                run_directed();
            else
            begin
                wait_idle();
                case (phase)
                    1:
                    begin
                        write_setting(CFG_STACK_TOP, '1);
                        write_setting(CFG_CODE_BASE, '1);
                    end
                    2:
                    begin
                        write_setting(CFG_UNUSED, 31'($urandom()));
                        write_setting(CFG_STACK_TOP, '0);
                        write_setting(CFG_CODE_BASE, '0);
                    end
                    3:
                    begin
                        write_setting(CFG_STACK_TOP, 31'($urandom()));
                        write_setting(CFG_CODE_BASE, 31'($urandom()));
                    end
                    default:
                    begin
                        // low stack top, so accesses below it wrap past zero
                        write_setting(CFG_CODE_BASE, 31'($urandom()));
                        write_setting(CFG_STACK_TOP, 31'($urandom_range(0, 3 * STACK_BYTES)));
                    end
                endcase
                cfg_ch.valid <= 1'b0;
            end
            repeat (RANDOM_PER_PHASE) send_instr(random_instr());
            item_ch.valid <= 1'b0;
        end

        wait_idle();
        if (mismatches == 0)
            $display("PASS small_arm_subset_executor");
        else
            $display("FAIL small_arm_subset_executor");
        $finish;
    end

endmodule
